// ===== src/page_bitmap_allocator_unit_assert.svh =====
// Assertion macros shared by the page bitmap allocator RTL.
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define PBA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Checks that a consequent holds in the cycle after its antecedent.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBA_ASSERT(lbl, expr, msg)
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/pba_pkg.sv =====
// Types, constants and helper functions of the page bitmap allocator.
package pba_pkg;

  localparam int TOTAL_PAGES    = 4096;
  localparam int RESERVED_PAGES = 256;
  localparam int WORD_BITS      = 32;
  localparam int MAP_WORDS      = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int FIRST_PAGE     = (RESERVED_PAGES < TOTAL_PAGES) ? RESERVED_PAGES : 0;

  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int ROW_W   = $clog2(MAP_WORDS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [ROW_W-1:0]     row_t;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_MARK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WR_RD,
    ST_WR_MOD,
    ST_RESP
  } state_e;

  // Contents of a map word straight after reset: reserved pages used, others free.
  function automatic word_t reset_word(row_t row);
    word_t w;
    for (int i = 0; i < WORD_BITS; i++) begin
      w[i] = ({row, BIT_W'(i)} >= PAGE_W'(FIRST_PAGE));
    end
    return w;
  endfunction

  // Search pointer after a run that ends just before the given page.
  function automatic page_t next_pointer(count_t run_end);
    if (run_end >= COUNT_W'(TOTAL_PAGES)) begin
      return PAGE_W'(FIRST_PAGE);
    end
    return run_end[PAGE_W-1:0];
  endfunction

endpackage

// ===== src/pba_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/page_bitmap_allocator_unit.sv =====
// Top level of the page bitmap allocator: sequencer, bitmap store and result register.
//
// Usage: one free bit per page is kept in a 128 x 32 bit RAM (1 means free).
// The input channel (in_valid_i, in_stall_o) carries action_i, page_index_i
// and page_count_i; the output channel (out_valid_o, out_stall_i) returns ok_o
// and granted_page_o, exactly one result transaction per input transaction.
// in_stall_o is high while a request is being worked on; requests are handled
// one at a time.
// Free and mark-used requests read and then rewrite each touched map word in
// turn. An allocation walks the map one page per cycle inside a word that
// holds free pages, pausing for the RAM read of each word it enters, skips a
// fully used word in a single step, and writes the granted run word by word
// like a free. The single RAM port pair sets this word-by-word access.
// Reset marks the pages below the first unreserved page used and the rest
// free at once (per-row valid flags, no clearing pass) and sets the search
// pointer to the first unreserved page. While the receiver stalls, the
// finished result waits in the output register and the next request may
// already be accepted and worked on up to its own result.
module page_bitmap_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [11:0] page_index_i,
  input  logic [12:0] page_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [11:0] granted_page_o
);

  `include "page_bitmap_allocator_unit_assert.svh"

  pba_pkg::state_e state_q, state_d;

  pba_pkg::page_t  p_q, p_d;
  pba_pkg::page_t  start_q, start_d;
  pba_pkg::count_t run_q, run_d;
  pba_pkg::count_t trav_q, trav_d;
  pba_pkg::count_t count_q, count_d;
  pba_pkg::page_t  ptr_q, ptr_d;
  pba_pkg::page_t  wr_first_q, wr_first_d;
  pba_pkg::page_t  wr_last_q, wr_last_d;
  pba_pkg::row_t   wr_row_q, wr_row_d;
  logic            wr_set_q, wr_set_d;
  logic            res_ok_q, res_ok_d;
  pba_pkg::page_t  res_grant_q, res_grant_d;
  logic            out_valid_q, out_valid_d;
  logic            out_ok_q, out_ok_d;
  pba_pkg::page_t  out_grant_q, out_grant_d;

  logic [pba_pkg::MAP_WORDS-1:0] row_valid_q;
  logic                          rd_valid_q;

  logic           ram_re;
  pba_pkg::row_t  ram_raddr;
  pba_pkg::word_t ram_rdata;
  logic           ram_we;
  pba_pkg::word_t ram_wdata;

  logic            in_fire;
  pba_pkg::word_t  cur_word;
  pba_pkg::count_t req_end;
  pba_pkg::count_t req_clip;

  // Scan step signals.
  logic            cur_bit;
  pba_pkg::count_t run_inc;
  pba_pkg::count_t p_ext;
  pba_pkg::count_t p_step;
  pba_pkg::count_t skip_to;
  pba_pkg::count_t trav_next;
  pba_pkg::page_t  p_next;
  pba_pkg::count_t run_next;
  logic            scan_hit;
  logic            scan_stop;
  pba_pkg::page_t  hit_first;

  // Write step signals.
  logic [pba_pkg::BIT_W-1:0] mask_lo;
  logic [pba_pkg::BIT_W-1:0] mask_hi;
  pba_pkg::word_t            wr_mask;

  assign in_stall_o = (state_q != pba_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Bitmap store.
  pba_ram #(
    .WIDTH(pba_pkg::WORD_BITS),
    .DEPTH(pba_pkg::MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A row never written since reset reads as its reset contents.
  assign cur_word = rd_valid_q ? ram_rdata : pba_pkg::reset_word(ram_raddr);

  // Clipped end (one past the last page) of a free or mark-used run.
  assign req_end  = {1'b0, page_index_i} + page_count_i;
  assign req_clip = (req_end > pba_pkg::COUNT_W'(pba_pkg::TOTAL_PAGES))
                    ? pba_pkg::COUNT_W'(pba_pkg::TOTAL_PAGES) : req_end;

  // One step of the next-fit scan on the page under the scan pointer.
  always_comb begin
    p_ext    = {1'b0, p_q};
    cur_bit  = cur_word[p_q[pba_pkg::BIT_W-1:0]];
    run_inc  = cur_bit ? (run_q + 1'b1) : '0;
    p_step   = p_ext + 1'b1;
    skip_to  = {1'b0, p_q | pba_pkg::PAGE_W'(pba_pkg::WORD_BITS - 1)} + 1'b1;
    if ((start_q > p_q) && ({1'b0, start_q} < skip_to)) begin
      skip_to = {1'b0, start_q};
    end
    scan_hit  = 1'b0;
    hit_first = p_q - run_inc[pba_pkg::PAGE_W-1:0] + 1'b1;
    if (cur_word != '0) begin
      scan_hit  = (run_inc >= count_q);
      trav_next = trav_q + 1'b1;
      if (p_step >= pba_pkg::COUNT_W'(pba_pkg::TOTAL_PAGES)) begin
        p_next   = pba_pkg::PAGE_W'(pba_pkg::FIRST_PAGE);
        run_next = '0;
      end else begin
        p_next   = p_step[pba_pkg::PAGE_W-1:0];
        run_next = run_inc;
      end
    end else begin
      trav_next = trav_q + (skip_to - p_ext);
      run_next  = '0;
      if (skip_to >= pba_pkg::COUNT_W'(pba_pkg::TOTAL_PAGES)) begin
        p_next = pba_pkg::PAGE_W'(pba_pkg::FIRST_PAGE);
      end else begin
        p_next = skip_to[pba_pkg::PAGE_W-1:0];
      end
    end
    scan_stop = (p_next == start_q)
                || (trav_next >= pba_pkg::COUNT_W'(pba_pkg::TOTAL_PAGES));
  end

  // Bit mask of the run within the map row being written.
  always_comb begin
    mask_lo = (wr_row_q == wr_first_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W])
              ? wr_first_q[pba_pkg::BIT_W-1:0] : '0;
    mask_hi = (wr_row_q == wr_last_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W])
              ? wr_last_q[pba_pkg::BIT_W-1:0] : '1;
    wr_mask = ({pba_pkg::WORD_BITS{1'b1}} << mask_lo)
              & ({pba_pkg::WORD_BITS{1'b1}} >> (~mask_hi));
    ram_wdata = wr_set_q ? (cur_word | wr_mask) : (cur_word & ~wr_mask);
  end

  // Sequencer: next state, datapath registers and RAM control.
  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    start_d     = start_q;
    run_d       = run_q;
    trav_d      = trav_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wr_first_d  = wr_first_q;
    wr_last_d   = wr_last_q;
    wr_row_d    = wr_row_q;
    wr_set_d    = wr_set_q;
    res_ok_d    = res_ok_q;
    res_grant_d = res_grant_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ok_d    = out_ok_q;
    out_grant_d = out_grant_q;
    ram_re      = 1'b0;
    ram_raddr   = p_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
    ram_we      = 1'b0;

    unique case (state_q)
      pba_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_ok_d    = 1'b0;
          res_grant_d = '0;
          count_d     = page_count_i;
          unique case (action_i) inside
            pba_pkg::ACT_ALLOC: begin
              p_d     = ptr_q;
              start_d = ptr_q;
              run_d   = '0;
              trav_d  = '0;
              state_d = (page_count_i == '0) ? pba_pkg::ST_RESP : pba_pkg::ST_LOAD;
            end
            pba_pkg::ACT_FREE, pba_pkg::ACT_MARK: begin
              ptr_d      = pba_pkg::next_pointer(req_end);
              wr_first_d = page_index_i;
              wr_last_d  = pba_pkg::PAGE_W'(req_clip - 1'b1);
              wr_row_d   = page_index_i[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
              wr_set_d   = (action_i == pba_pkg::ACT_FREE);
              res_ok_d   = (page_count_i != '0);
              state_d    = (page_count_i == '0) ? pba_pkg::ST_RESP : pba_pkg::ST_WR_RD;
            end
            default: begin
              state_d = pba_pkg::ST_RESP;
            end
          endcase
        end
      end

      pba_pkg::ST_LOAD: begin
        ram_re  = 1'b1;
        state_d = pba_pkg::ST_SCAN;
      end

      pba_pkg::ST_SCAN: begin
        if (scan_hit) begin
          ptr_d       = pba_pkg::next_pointer({1'b0, hit_first} + count_q);
          wr_first_d  = hit_first;
          wr_last_d   = pba_pkg::PAGE_W'({1'b0, hit_first} + count_q - 1'b1);
          wr_row_d    = hit_first[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
          wr_set_d    = 1'b0;
          res_ok_d    = 1'b1;
          res_grant_d = hit_first;
          state_d     = pba_pkg::ST_WR_RD;
        end else if (scan_stop) begin
          state_d = pba_pkg::ST_RESP;
        end else begin
          p_d    = p_next;
          run_d  = run_next;
          trav_d = trav_next;
          if (p_next[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]
              != p_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]) begin
            state_d = pba_pkg::ST_LOAD;
          end
        end
      end

      pba_pkg::ST_WR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = wr_row_q;
        state_d   = pba_pkg::ST_WR_MOD;
      end

      pba_pkg::ST_WR_MOD: begin
        ram_raddr = wr_row_q;
        ram_we    = 1'b1;
        if (wr_row_q == wr_last_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]) begin
          state_d = pba_pkg::ST_RESP;
        end else begin
          wr_row_d = wr_row_q + 1'b1;
          state_d  = pba_pkg::ST_WR_RD;
        end
      end

      pba_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_grant_d = res_grant_q;
          state_d     = pba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pba_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pba_pkg::ST_IDLE;
      ptr_q       <= pba_pkg::PAGE_W'(pba_pkg::FIRST_PAGE);
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        row_valid_q[wr_row_q] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    start_q     <= start_d;
    run_q       <= run_d;
    trav_q      <= trav_d;
    count_q     <= count_d;
    wr_first_q  <= wr_first_d;
    wr_last_q   <= wr_last_d;
    wr_row_q    <= wr_row_d;
    wr_set_q    <= wr_set_d;
    res_ok_q    <= res_ok_d;
    res_grant_q <= res_grant_d;
    out_ok_q    <= out_ok_d;
    out_grant_q <= out_grant_d;
    if (ram_re) begin
      rd_valid_q <= row_valid_q[ram_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign granted_page_o = out_grant_q;

  // A failed or non-allocating result never carries a page.
  `PBA_ASSERT(a_fail_no_grant, !out_valid_o || ok_o || (granted_page_o == '0), "failed result carries a page")
  // The write sweep never goes past the last row of the run.
  `PBA_ASSERT(a_wr_row_bound, (state_q != pba_pkg::ST_WR_MOD) || (wr_row_q <= wr_last_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]), "write sweep ran past the run")
  // An accepted request always leaves the idle state.
  `PBA_ASSERT_NEXT(a_accept_busy, in_fire, state_q != pba_pkg::ST_IDLE, "accepted request not started")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the page bitmap allocator unit.
module testbench;
  import pba_pkg::*;

  // Action code outside the defined set; the block must answer with a failed result.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned RANDOM_REQUESTS = 1330;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS = 10;

  // One row of the directed table: the request and, where known by hand, its result.
  typedef struct packed {
    logic [1:0] action;
    page_t      index;
    count_t     count;
    logic       hand_checked;
    logic       ok;
    page_t      granted;
  } request_row_t;

  typedef struct packed {
    logic  ok;
    page_t granted;
  } grant_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [1:0] in_action = ACT_ALLOC;
  page_t      in_index = '0;
  count_t     in_count = '0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic       ok_o;
  page_t      granted_page_o;

  request_row_t  directed_rows[$];
  grant_result_t pending_grants[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  // Predictor state: one free bit per page and the next-fit search pointer.
  logic [WORD_BITS-1:0] free_pages [MAP_WORDS];
  int unsigned          scan_pointer;

  page_bitmap_allocator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .action_i       (in_action),
    .page_index_i   (in_index),
    .page_count_i   (in_count),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .ok_o           (ok_o),
    .granted_page_o (granted_page_o)
  );

  // Clock with a period of ten time units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sets or clears a run clipped at the last page, then moves the pointer past it.
  function automatic void write_page_run(int unsigned first, int unsigned count,
                                         logic make_free);
    int unsigned stop;
    stop = first + count;
    if (stop > TOTAL_PAGES) begin
      stop = TOTAL_PAGES;
    end
    for (int unsigned p = first; p < stop; p++) begin
      free_pages[p / WORD_BITS][p % WORD_BITS] = make_free;
    end
    scan_pointer = (first + count >= TOTAL_PAGES) ? FIRST_PAGE : first + count;
  endfunction

  // Next-fit search for a run of free pages, skipping fully used words at once.
  function automatic logic find_free_run(int unsigned count, output int unsigned first);
    int unsigned origin;
    int unsigned p;
    int unsigned run;
    int unsigned next_p;
    longint unsigned covered;
    logic [WORD_BITS-1:0] w;
    first = 0;
    if (count == 0) begin
      return 1'b0;
    end
    origin = scan_pointer;
    p = origin;
    run = 0;
    covered = 0;
    do begin
      w = free_pages[p / WORD_BITS];
      if (w != '0) begin
        if (w[p % WORD_BITS]) begin
          run++;
        end else begin
          run = 0;
        end
        if (run >= count) begin
          first = p - run + 1;
          write_page_run(first, count, 1'b0);
          return 1'b1;
        end
        p++;
        covered++;
        // A free run never continues across the wrap.
        if (p >= TOTAL_PAGES) begin
          p = FIRST_PAGE;
          run = 0;
        end
      end else begin
        next_p = (p | (WORD_BITS - 1)) + 1;
        if (origin > p && origin < next_p) begin
          next_p = origin;
        end
        covered += next_p - p;
        p = next_p;
        run = 0;
        if (p >= TOTAL_PAGES) begin
          p = FIRST_PAGE;
        end
      end
    end while (p != origin && covered < TOTAL_PAGES);
    first = 0;
    return 1'b0;
  endfunction

  // Works out the result of one request and updates the predicted bitmap.
  function automatic grant_result_t predict_grant(logic [1:0] act, page_t idx, count_t cnt);
    grant_result_t r;
    int unsigned first;
    r = '0;
    case (act) inside
      ACT_ALLOC: begin
        r.ok = find_free_run(cnt, first);
        if (r.ok) begin
          r.granted = page_t'(first);
        end
      end
      ACT_FREE, ACT_MARK: begin
        write_page_run(idx, cnt, act == ACT_FREE);
        r.ok = (cnt != 0);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [1:0] act, int unsigned idx, int unsigned cnt,
                                  logic hand_checked, logic ok, int unsigned granted);
    request_row_t row;
    row.action = act;
    row.index = page_t'(idx);
    row.count = count_t'(cnt);
    row.hand_checked = hand_checked;
    row.ok = ok;
    row.granted = page_t'(granted);
    directed_rows.push_back(row);
  endfunction

  function automatic void note_mismatch(string what, int unsigned expected, int unsigned actual);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("Mismatch in %s: expected %0d, got %0d", what, expected, actual);
    end
  endfunction

  // Drives one request transaction, waits for its acceptance and records the expected result.
  task automatic send_request(logic [1:0] act, page_t idx, count_t cnt, logic hand_checked,
                              logic hand_ok, page_t hand_granted);
    grant_result_t predicted;
    in_valid <= 1'b1;
    in_action <= act;
    in_index <= idx;
    in_count <= cnt;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predicted = predict_grant(act, idx, cnt);
    if (hand_checked) begin
      predicted.ok = hand_ok;
      predicted.granted = hand_granted;
    end
    pending_grants.push_back(predicted);
  endtask

  // Result checking and the receiver's stall pattern.
  int unsigned stall_hold = 0;
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    grant_result_t exp_grant;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_grants.size() == 0) begin
        note_mismatch("unexpected result transaction, ok", 0, ok_o);
      end else begin
        exp_grant = pending_grants.pop_front();
        if (ok_o !== exp_grant.ok) begin
          note_mismatch("ok", exp_grant.ok, ok_o);
        end
        if (granted_page_o !== exp_grant.granted) begin
          note_mismatch("granted_page", exp_grant.granted, granted_page_o);
        end
      end
    end
    // Alternate windows with no stalling and windows of random stall runs.
    stall_phase = (stall_phase + 1) % 600;
    if (stall_phase < 150) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold == 0) begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = $urandom_range(0, 12);
    end else begin
      stall_hold--;
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus: directed table first, then random requests in bursts.
  initial begin
    int unsigned burst_left;
    int unsigned pick;
    logic [1:0]  act;
    page_t       idx;
    count_t      cnt;

    // Predictor reset: reserved pages used, all others free.
    for (int unsigned p = 0; p < TOTAL_PAGES; p++) begin
      free_pages[p / WORD_BITS][p % WORD_BITS] = (p >= FIRST_PAGE);
    end
    scan_pointer = FIRST_PAGE;

    add_row(ACT_ALLOC,   0,     1,     1'b1, 1'b1, FIRST_PAGE);
    add_row(ACT_ALLOC,   0,     0,     1'b1, 1'b0, 0);
    // A zero count still moves the pointer, here to the last page.
    add_row(ACT_FREE,    4095,  0,     1'b1, 1'b0, 0);
    add_row(ACT_ALLOC,   0,     1,     1'b1, 1'b1, 4095);
    // Runs past the last page are clipped.
    add_row(ACT_MARK,    4090,  4096,  1'b1, 1'b1, 0);
    add_row(ACT_FREE,    0,     4096,  1'b1, 1'b1, 0);
    add_row(ACT_MARK,    0,     256,   1'b1, 1'b1, 0);
    add_row(ACT_UNKNOWN, 4095,  4096,  1'b1, 1'b0, 0);
    // Larger than every free run, then the whole unreserved area, then a full map.
    add_row(ACT_ALLOC,   0,     4096,  1'b1, 1'b0, 0);
    add_row(ACT_ALLOC,   0,     3840,  1'b1, 1'b1, 256);
    add_row(ACT_ALLOC,   0,     1,     1'b1, 1'b0, 0);
    // A lone free page found only after wrapping round.
    add_row(ACT_FREE,    1000,  1,     1'b1, 1'b1, 0);
    add_row(ACT_ALLOC,   0,     1,     1'b1, 1'b1, 1000);
    // Free runs at both ends of the map must not join across the wrap.
    add_row(ACT_FREE,    4000,  200,   1'b1, 1'b1, 0);
    add_row(ACT_FREE,    256,   10,    1'b1, 1'b1, 0);
    add_row(ACT_MARK,    4000,  0,     1'b1, 1'b0, 0);
    add_row(ACT_ALLOC,   0,     100,   1'b1, 1'b0, 0);
    add_row(ACT_ALLOC,   0,     96,    1'b1, 1'b1, 4000);
    add_row(ACT_ALLOC,   0,     10,    1'b1, 1'b1, 256);
    add_row(ACT_FREE,    255,   2,     1'b1, 1'b1, 0);
    add_row(ACT_FREE,    'hAAA, 'h555, 1'b1, 1'b1, 0);
    add_row(ACT_MARK,    'h555, 'hAAA, 1'b1, 1'b1, 0);
    add_row(ACT_ALLOC,   'hFFF, 'hFFF, 1'b0, 1'b0, 0);
    add_row(ACT_ALLOC,   0,     33,    1'b0, 1'b0, 0);
    add_row(ACT_FREE,    256,   3840,  1'b1, 1'b1, 0);
    add_row(ACT_UNKNOWN, 0,     0,     1'b1, 1'b0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 20);
    for (int unsigned i = 0; i < directed_rows.size() + RANDOM_REQUESTS; i++) begin
      if (i < directed_rows.size()) begin
        send_request(directed_rows[i].action, directed_rows[i].index, directed_rows[i].count,
                     directed_rows[i].hand_checked, directed_rows[i].ok,
                     directed_rows[i].granted);
      end else begin
        pick = $urandom_range(0, 99);
        idx = page_t'($urandom_range(0, 4095));
        if (pick < 45) begin
          // Mostly small allocations, a few large ones and the odd zero count.
          act = ACT_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 80) begin
            cnt = count_t'($urandom_range(1, 32));
          end else if (pick < 95) begin
            cnt = count_t'($urandom_range(33, 256));
          end else if (pick < 99) begin
            cnt = count_t'($urandom_range(257, 4096));
          end else begin
            cnt = '0;
          end
        end else if (pick < 47) begin
          // Give back the whole unreserved area so the map does not stay full.
          act = ACT_FREE;
          idx = page_t'(FIRST_PAGE);
          cnt = count_t'(TOTAL_PAGES - FIRST_PAGE);
        end else if (pick < 95) begin
          act = (pick < 77) ? ACT_FREE : ACT_MARK;
          if ($urandom_range(0, 9) != 0) begin
            idx = page_t'($urandom_range(FIRST_PAGE, TOTAL_PAGES - 1));
          end
          pick = $urandom_range(0, 99);
          if (pick < 85) begin
            cnt = count_t'($urandom_range(1, (act == ACT_FREE) ? 64 : 32));
          end else if (pick < 92) begin
            cnt = '0;
          end else begin
            cnt = count_t'($urandom_range(65, 4096));
          end
        end else begin
          act = ACT_UNKNOWN;
          cnt = count_t'($urandom_range(0, 4096));
        end
        send_request(act, idx, cnt, 1'b0, 1'b0, '0);
      end
      // Bursts of back-to-back transactions separated by idle gaps.
      burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
    end
    in_valid <= 1'b0;

    while (pending_grants.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
